// ----- rtl/gwm_pkg.sv -----
package gwm_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int TEXT_DEPTH    = 256;

  // address and length widths of the two stores
  localparam int PAT_AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int TXT_AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PAT_LW = $clog2(PATTERN_DEPTH + 1);
  localparam int TXT_LW = $clog2(TEXT_DEPTH + 1);

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  typedef enum logic [1:0] {
    ACT_PATTERN = 2'd0,
    ACT_TEXT    = 2'd1,
    ACT_EVAL    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflowed;
  } out_item_t;

  // microcode
  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_FETCH = 2'd1;
  localparam step_t STEP_MATCH = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_FETCH,
    OP_MATCH,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    C_EVAL,
    C_OVF,
    C_FINISH,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } uword_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      STEP_IDLE:  w = '{op: OP_IDLE,  cond: C_EVAL,     tgt_true: STEP_FETCH, tgt_false: STEP_IDLE};
      STEP_FETCH: w = '{op: OP_FETCH, cond: C_OVF,      tgt_true: STEP_EMIT,  tgt_false: STEP_MATCH};
      STEP_MATCH: w = '{op: OP_MATCH, cond: C_FINISH,   tgt_true: STEP_EMIT,  tgt_false: STEP_FETCH};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FREE, tgt_true: STEP_IDLE,  tgt_false: STEP_EMIT};
      default:    w = '{op: OP_IDLE,  cond: C_EVAL,     tgt_true: STEP_FETCH, tgt_false: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/glob_wildcard_matcher_unit.sv -----
// channel | ports                          | transfer when
// input   | in_valid, in_stall, in_data    | in_valid && !in_stall
// result  | out_valid, out_stall, out_data | out_valid && !out_stall
//
// pattern and text appends are taken back to back while no evaluate is running.
// evaluate runs a four-step microprogram: a store read in fetch, a decision in
// match, overflow skipping to emit; backtracking to the last star sets how many
// fetch/match rounds run, at most about pattern length times text length.
// in_stall is high from evaluate until its result is in the output register.
// reset clears lengths, overflow flag and control; the stores are not cleared.
module glob_wildcard_matcher_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gwm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gwm_pkg::out_item_t out_data
);

  logic [7:0] pat_mem [gwm_pkg::PATTERN_DEPTH];
  logic [7:0] txt_mem [gwm_pkg::TEXT_DEPTH];
  logic [7:0] pat_q, txt_q;

  gwm_pkg::step_t upc_r, upc_nxt;
  gwm_pkg::uword_t uw;

  logic [gwm_pkg::PAT_LW-1:0] plen_r, plen_nxt, p_r, p_nxt, rp_r, rp_nxt;
  logic [gwm_pkg::TXT_LW-1:0] tlen_r, tlen_nxt, t_r, t_nxt, rt_r, rt_nxt;
  logic have_r, have_nxt, ovf_r, ovf_nxt, res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  gwm_pkg::out_item_t out_data_r;

  logic in_xfer, pat_we, txt_we, fin, cond_hit, out_free;
  logic p_in, t_in, is_star, is_hit;

  assign uw       = gwm_pkg::ucode(upc_r);
  assign in_stall = (uw.op != gwm_pkg::OP_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pat_we   = in_xfer && (in_data.action == gwm_pkg::ACT_PATTERN) &&
                    (plen_r < gwm_pkg::PAT_LW'(gwm_pkg::PATTERN_DEPTH));
  assign txt_we   = in_xfer && (in_data.action == gwm_pkg::ACT_TEXT) &&
                    (tlen_r < gwm_pkg::TXT_LW'(gwm_pkg::TEXT_DEPTH));

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[plen_r[gwm_pkg::PAT_AW-1:0]] <= in_data.char_code;
    end
    if (txt_we) begin
      txt_mem[tlen_r[gwm_pkg::TXT_AW-1:0]] <= in_data.char_code;
    end
    pat_q <= pat_mem[p_r[gwm_pkg::PAT_AW-1:0]];
    txt_q <= txt_mem[t_r[gwm_pkg::TXT_AW-1:0]];
  end

  assign p_in    = p_r < plen_r;
  assign t_in    = t_r < tlen_r;
  assign is_star = pat_q == gwm_pkg::STAR_BYTE;
  assign is_hit  = (pat_q == gwm_pkg::ANY_BYTE) || (pat_q == txt_q);

  always_comb begin
    plen_nxt      = plen_r;
    tlen_nxt      = tlen_r;
    p_nxt         = p_r;
    t_nxt         = t_r;
    rp_nxt        = rp_r;
    rt_nxt        = rt_r;
    have_nxt      = have_r;
    ovf_nxt       = ovf_r;
    res_nxt       = res_r;
    fin           = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (uw.op)
      gwm_pkg::OP_IDLE: begin
        if (in_xfer) begin
          case (in_data.action)
            gwm_pkg::ACT_PATTERN: begin
              if (pat_we) plen_nxt = plen_r + 1'b1;
              else ovf_nxt = 1'b1;
            end
            gwm_pkg::ACT_TEXT: begin
              if (txt_we) tlen_nxt = tlen_r + 1'b1;
              else ovf_nxt = 1'b1;
            end
            gwm_pkg::ACT_EVAL: begin
              p_nxt    = '0;
              t_nxt    = '0;
              rp_nxt   = '0;
              rt_nxt   = '0;
              have_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      gwm_pkg::OP_FETCH: begin
        // overflow skips matching and forces no-match
        if (ovf_r) res_nxt = 1'b0;
      end
      gwm_pkg::OP_MATCH: begin
        if (t_in) begin
          if (p_in && is_star) begin
            have_nxt = 1'b1;
            p_nxt    = p_r + 1'b1;
            rp_nxt   = p_r + 1'b1;
            rt_nxt   = t_r;
          end else if (p_in && is_hit) begin
            p_nxt = p_r + 1'b1;
            t_nxt = t_r + 1'b1;
          end else if (have_r) begin
            // star absorbs one more text byte
            rt_nxt = rt_r + 1'b1;
            p_nxt  = rp_r;
            t_nxt  = rt_r + 1'b1;
          end else begin
            fin     = 1'b1;
            res_nxt = 1'b0;
          end
        end else if (p_in && is_star) begin
          p_nxt = p_r + 1'b1;
        end else begin
          fin     = 1'b1;
          res_nxt = (p_r == plen_r);
        end
      end
      gwm_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          plen_nxt      = '0;
          tlen_nxt      = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase

    case (uw.cond)
      gwm_pkg::C_EVAL:     cond_hit = in_xfer && (in_data.action == gwm_pkg::ACT_EVAL);
      gwm_pkg::C_OVF:      cond_hit = ovf_r;
      gwm_pkg::C_FINISH:   cond_hit = fin;
      gwm_pkg::C_OUT_FREE: cond_hit = out_free;
      default:             cond_hit = 1'b0;
    endcase
    upc_nxt = cond_hit ? uw.tgt_true : uw.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= gwm_pkg::STEP_IDLE;
      plen_r      <= '0;
      tlen_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      plen_r      <= plen_nxt;
      tlen_r      <= tlen_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    t_r    <= t_nxt;
    rp_r   <= rp_nxt;
    rt_r   <= rt_nxt;
    have_r <= have_nxt;
    res_r  <= res_nxt;
    if ((uw.op == gwm_pkg::OP_EMIT) && out_free) begin
      out_data_r.matched    <= res_r && !ovf_r;
      out_data_r.overflowed <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflowed |-> !out_data.matched)
    else $error("overflowed result reports a match");

  a_eval_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.action == gwm_pkg::ACT_EVAL) |=> in_stall)
    else $error("input not stalled after evaluate transfer");

  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= gwm_pkg::PAT_LW'(gwm_pkg::PATTERN_DEPTH) &&
    tlen_r <= gwm_pkg::TXT_LW'(gwm_pkg::TEXT_DEPTH))
    else $error("store length beyond depth");

  a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == gwm_pkg::OP_MATCH) |-> (p_r <= plen_r) && (t_r <= tlen_r))
    else $error("match index beyond store length");
`endif

endmodule
